### src/pcmd_pkg.sv
// Shared types and constants for the PCM multichannel to mono downmix block.
// Holds format codes, configuration register indexes, controller states and
// the command/status structs between controller and datapath. No dependencies.
package pcmd_pkg;

  localparam int Q_W        = 32;  // Q1.31 sample width
  localparam int FMT_W      = 3;   // sample_format register width
  localparam int CNT_REG_W  = 4;   // channel_count register width
  localparam int CFG_IDX_W  = 1;   // configuration register index width
  localparam int CFG_DATA_W = 4;   // widest configuration register

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

  // reset values of the configuration registers
  localparam logic [FMT_W-1:0]     FORMAT_RESET = 3'd1;
  localparam logic [CNT_REG_W-1:0] COUNT_RESET  = 4'd2;

  // sample format codes; any other code gives zero samples
  localparam logic [FMT_W-1:0] FMT_FLOAT32 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_INT16   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_INT24   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_INT32   = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ADD,
    ST_START,
    ST_DIV,
    ST_FIN
  } pcmd_state_t;

  typedef struct packed {
    logic load;       // capture the accepted request
    logic conv;       // register the normalized sample
    logic add;        // accumulate into the frame sum
    logic div_start;  // load the divider from the frame sum
    logic div_step;   // one quotient bit
    logic out_load;   // write the result register
  } pcmd_cmd_t;

  typedef struct packed {
    logic frame_end;  // current sample closes the frame
    logic div_last;   // divider is on its final step
    logic out_free;   // result register can take a new value
  } pcmd_status_t;

endpackage

### src/pcm_multichannel_to_mono_downmix.sv
// A frame-closing request gives its result after capture, normalize,
// accumulate and the divider; other requests produce no result.
// Requests are taken one at a time; a frame-closing request holds the
// input while the divider runs, and longer while a prior result waits.
// Reset (rst, synchronous, active high): format int16, 2 channels, frame
// state cleared, no result pending.
module pcm_multichannel_to_mono_downmix #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [pcmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcmd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel: one interleaved channel word per request
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pcmd_pkg::Q_W-1:0]          sample_word,
  input  logic                              silent,
  input  logic                              packet_end,
  // output channel: one mono sample per frame
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pcmd_pkg::Q_W-1:0]   mono_sample,
  output logic                              packet_last
);
  import pcmd_pkg::*;

  pcmd_cmd_t    cmd;
  pcmd_status_t status;

  // Controller: walks each request through capture, normalize and
  // accumulate; at a frame end it runs the divider, then holds until the
  // result register is free. The result register lets the next request
  // enter while a finished sample still waits downstream.
  pcmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath: config registers, Q1.31 normalizer, 1..MAX_CHANNELS frame
  // sum, signed average truncated toward zero, result register.
  pcmd_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_word (sample_word),
    .silent      (silent),
    .packet_end  (packet_end),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .mono_sample (mono_sample),
    .packet_last (packet_last),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

### src/pcmd_norm.sv
// Sample normalizer: converts one raw channel word to signed Q1.31 by format.
// Depends on pcmd_pkg for format codes and widths.
module pcmd_norm (
  input  logic [pcmd_pkg::FMT_W-1:0] sample_format,
  input  logic [pcmd_pkg::Q_W-1:0]   word,
  input  logic                       silent,
  output logic signed [pcmd_pkg::Q_W-1:0] value
);
  import pcmd_pkg::*;

  logic        f_sign;
  logic [7:0]  f_exp;
  logic [22:0] f_frac;
  logic [7:0]  exp_eff;
  logic [23:0] mant;
  logic [7:0]  rsh;
  logic [7:0]  lsh;
  logic [30:0] mag;
  logic [Q_W-1:0] sat;
  logic [Q_W-1:0] fval;

  // float32 -> Q1.31, truncate toward zero, saturate, NaN to zero
  always_comb begin
    f_sign  = word[31];
    f_exp   = word[30:23];
    f_frac  = word[22:0];
    exp_eff = (f_exp == 8'd0) ? 8'd1 : f_exp;
    mant    = {(f_exp != 8'd0), f_frac};
    rsh     = 8'd119 - exp_eff;
    lsh     = exp_eff - 8'd119;
    sat     = f_sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (exp_eff >= 8'd119) begin
      mag = {7'd0, mant} << lsh[2:0];
    end else if (rsh >= 8'd24) begin
      mag = '0;
    end else begin
      mag = {7'd0, mant >> rsh[4:0]};
    end
    if (f_exp == 8'hFF) begin
      fval = (f_frac != 23'd0) ? '0 : sat;
    end else if (exp_eff >= 8'd127) begin
      fval = sat;
    end else begin
      fval = f_sign ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
    end
  end

  always_comb begin
    if (silent) begin
      value = '0;
    end else begin
      case (sample_format)
        FMT_FLOAT32: value = fval;
        FMT_INT16:   value = {word[15:0], 16'd0};
        FMT_INT24:   value = {word[23:0], 8'd0};
        FMT_INT32:   value = word;
        default:     value = '0;
      endcase
    end
  end

endmodule

### src/pcmd_ctrl.sv
// Controller state machine: sequences capture, normalize, accumulate,
// divide and result write. Depends on pcmd_pkg for state and command types.
module pcmd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  pcmd_pkg::pcmd_status_t status,
  output logic                   in_ready,
  output pcmd_pkg::pcmd_cmd_t    cmd
);
  import pcmd_pkg::*;

  pcmd_state_t state;
  pcmd_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CONV;
      ST_CONV:  state_next = ST_ADD;
      ST_ADD:   state_next = status.frame_end ? ST_START : ST_IDLE;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (status.div_last) state_next = ST_FIN;
      ST_FIN:   if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV:  cmd.conv      = 1'b1;
      ST_ADD:   cmd.add       = 1'b1;
      ST_START: cmd.div_start = 1'b1;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_FIN:   cmd.out_load  = status.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

### src/pcmd_dp.sv
// Datapath: configuration registers, request capture, normalizer, frame
// accumulator, bit-serial divider and result register. Uses pcmd_pkg, pcmd_norm.
module pcmd_dp #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pcmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcmd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [pcmd_pkg::Q_W-1:0]          sample_word,
  input  logic                              silent,
  input  logic                              packet_end,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [pcmd_pkg::Q_W-1:0]   mono_sample,
  output logic                              packet_last,
  input  pcmd_pkg::pcmd_cmd_t               cmd,
  output pcmd_pkg::pcmd_status_t            status
);
  import pcmd_pkg::*;

  localparam int SUM_W  = Q_W + $clog2(MAX_CHANNELS);
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CMP_W  = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;
  localparam int EXT_W  = CNT_REG_W + 1;
  localparam int STEP_W = $clog2(SUM_W);

  logic [FMT_W-1:0]     sample_format;
  logic [CNT_REG_W-1:0] channel_count;

  logic [Q_W-1:0]       raw_word;
  logic                 raw_silent;
  logic                 raw_pend;
  logic signed [Q_W-1:0] norm_value;
  logic signed [Q_W-1:0] norm_q;

  logic signed [SUM_W-1:0] frame_sum;
  logic [POS_W-1:0]        channel_position;
  logic                    packet_seen;

  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic              div_neg;
  logic              div_pkt;
  logic [STEP_W-1:0] step_cnt;

  logic [EXT_W-1:0]  count_ext;
  logic [CNT_W-1:0]  eff_count;
  logic [CNT_W:0]    shifted;
  logic              fits;
  logic [SUM_W-1:0]  sum_mag;
  logic [SUM_W-1:0]  result;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FORMAT_RESET;
      channel_count <= COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SAMPLE_FORMAT: sample_format <= cfg_data[FMT_W-1:0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the channel count to 1..MAX_CHANNELS
  always_comb begin
    count_ext = {1'b0, channel_count};
    if (count_ext == '0) begin
      eff_count = CNT_W'(1);
    end else if (count_ext > EXT_W'(MAX_CHANNELS)) begin
      eff_count = CNT_W'(MAX_CHANNELS);
    end else begin
      eff_count = count_ext[CNT_W-1:0];
    end
  end

  pcmd_norm u_norm (
    .sample_format (sample_format),
    .word          (raw_word),
    .silent        (raw_silent),
    .value         (norm_value)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_word   <= sample_word;
      raw_silent <= silent;
      raw_pend   <= packet_end;
    end
    if (cmd.conv) begin
      norm_q <= norm_value;
    end
  end

  assign status.frame_end =
    (CMP_W'(channel_position) + CMP_W'(1)) >= CMP_W'(eff_count);

  // frame accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sum        <= '0;
      channel_position <= '0;
      packet_seen      <= 1'b0;
    end else if (cmd.add) begin
      frame_sum   <= frame_sum + SUM_W'(norm_q);
      packet_seen <= packet_seen | raw_pend;
      if (status.frame_end) begin
        channel_position <= '0;
      end else begin
        channel_position <= channel_position + POS_W'(1);
      end
    end else if (cmd.div_start) begin
      frame_sum   <= '0;
      packet_seen <= 1'b0;
    end
  end

  // restoring divider, one quotient bit per step
  assign sum_mag = frame_sum[SUM_W-1] ? (SUM_W'(0) - frame_sum) : frame_sum;
  assign shifted = {rem, quo[SUM_W-1]};
  assign fits    = shifted >= {1'b0, divisor};
  assign status.div_last = (step_cnt == STEP_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo      <= sum_mag;
      rem      <= '0;
      divisor  <= eff_count;
      div_neg  <= frame_sum[SUM_W-1];
      div_pkt  <= packet_seen;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      quo      <= {quo[SUM_W-2:0], fits};
      rem      <= fits ? CNT_W'(shifted - {1'b0, divisor}) : shifted[CNT_W-1:0];
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  assign result = div_neg ? (SUM_W'(0) - quo) : quo;
  assign status.out_free = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mono_sample <= result[Q_W-1:0];
      packet_last <= div_pkt;
    end
  end

endmodule

### src/pcmd_checker.sv
// Port-level checker for the downmix block, attached to the top level by bind.
// Depends on pcmd_pkg for field widths.
module pcmd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [pcmd_pkg::Q_W-1:0] mono_sample,
  input logic                            packet_last
);
  import pcmd_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mono_sample) && $stable(packet_last))
    else $error("stalled result changed or dropped");

  // come out of reset ready with nothing pending
  a_reset: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("bad state after reset");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // no result can appear the cycle right after a request
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind pcm_multichannel_to_mono_downmix pcmd_checker u_pcmd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .mono_sample (mono_sample),
  .packet_last (packet_last)
);
